// ===== sv/obb_pkg.sv =====
`timescale 1ns / 1ps
package obb_pkg;
   // Number of candidate axes and the code reported when none separates.
   localparam int unsigned NumAxes = 15;
   localparam logic [3:0] AxisNone = 4'd15;

   // Result of one box pair.
   typedef struct packed {
      logic       overlap;
      logic [3:0] separating_axis;
   } rsp_type;
endpackage

// ===== sv/obb_if.sv =====
`timescale 1ns / 1ps
interface obb_req_if #(parameter int unsigned FieldWidth = 48) ();
   logic                  valid;
   logic                  ready;
   logic [FieldWidth-1:0] a_center;
   logic [FieldWidth-1:0] b_center;
   logic [FieldWidth-1:0] a_half_extents;
   logic [FieldWidth-1:0] b_half_extents;
   logic [FieldWidth-1:0] a_axis_0;
   logic [FieldWidth-1:0] a_axis_1;
   logic [FieldWidth-1:0] a_axis_2;
   logic [FieldWidth-1:0] b_axis_0;
   logic [FieldWidth-1:0] b_axis_1;
   logic [FieldWidth-1:0] b_axis_2;
   modport source (output valid, a_center, b_center, a_half_extents, b_half_extents,
      a_axis_0, a_axis_1, a_axis_2, b_axis_0, b_axis_1, b_axis_2, input ready);
   modport sink (input valid, a_center, b_center, a_half_extents, b_half_extents,
      a_axis_0, a_axis_1, a_axis_2, b_axis_0, b_axis_1, b_axis_2, output ready);
endinterface

interface obb_rsp_if ();
   logic       valid;
   logic       ready;
   logic       overlap;
   logic [3:0] separating_axis;
   modport source (output valid, overlap, separating_axis, input ready);
   modport sink (input valid, overlap, separating_axis, output ready);
endinterface

// ===== sv/obb_overlap_separating_axis_top.sv =====
`timescale 1ns / 1ps
// Oriented box overlap test by the 15-axis separating axis method. Each request carries
// two boxes (centres and half extents in signed Q9.6, unit axes in signed Q1.(W-2),
// W = COMPONENT_WIDTH, three components packed x low). The response gives an overlap
// flag and the first separating axis: 0-2 box A axes, 3-5 box B axes, 6+3i+j for
// Ai x Bj, 15 for none. A new request is taken every cycle unless a stalled response
// holds the pipe; each one passes five register stages (dot products, flooring,
// radius products, sums, compare and priority pick) before its response is valid.
// All stages advance together under one enable, so a stalled response holds the
// whole pipe.
module obb_overlap_separating_axis_top
   import obb_pkg::*;
#(
   parameter int unsigned COMPONENT_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   obb_req_if.sink   req,
   obb_rsp_if.source rsp
);
   localparam int unsigned W  = COMPONENT_WIDTH;
   localparam int unsigned AF = W - 2;
   // Exact product widths.
   localparam int unsigned PW = 2 * W + 2;       // three-term dot of two W-bit values
   localparam int unsigned DW = W + 1;           // centre difference
   localparam int unsigned TW = W + DW + 2;      // dot with difference
   localparam int unsigned CW = PW - AF;         // floored axis dot
   localparam int unsigned FW = TW - AF;         // floored projection
   localparam int unsigned RW = W + CW + 4;      // radius term and sums
   localparam int unsigned XW = FW + CW + 2;     // cross projection
   localparam int unsigned SW = (RW > XW ? RW : XW) + AF + 2;

   typedef logic signed [W-1:0]  comp_type;
   typedef logic signed [CW-1:0] c_type;
   typedef logic signed [FW-1:0] t_type;
   typedef logic signed [SW-1:0] s_type;

   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // Bits above the 48-bit field read as zero.
   function automatic comp_type get_comp(input logic [47:0] v, input int unsigned k);
      logic [63:0] wide;
      wide = 64'(v);
      get_comp = comp_type'(wide[k*W +: W]);
   endfunction

   // Unpack components.
   comp_type ax [3][3];
   comp_type bx [3][3];
   comp_type ea [3];
   comp_type eb [3];
   logic signed [DW-1:0] d [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ax[0][k] = get_comp(req.a_axis_0, k);
         ax[1][k] = get_comp(req.a_axis_1, k);
         ax[2][k] = get_comp(req.a_axis_2, k);
         bx[0][k] = get_comp(req.b_axis_0, k);
         bx[1][k] = get_comp(req.b_axis_1, k);
         bx[2][k] = get_comp(req.b_axis_2, k);
         ea[k] = get_comp(req.a_half_extents, k);
         eb[k] = get_comp(req.b_half_extents, k);
         d[k] = DW'(get_comp(req.b_center, k)) - DW'(get_comp(req.a_center, k));
      end
   end

   // Stage 1: raw dot products.
   logic                 v1_ff;
   logic signed [PW-1:0] c1_ff [3][3];
   logic signed [TW-1:0] ta1_ff [3];
   logic signed [TW-1:0] tb1_ff [3];
   comp_type             ea1_ff [3];
   comp_type             eb1_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req.valid;
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
               c1_ff[i][j] <= PW'(ax[i][0] * bx[j][0]) + PW'(ax[i][1] * bx[j][1])
                  + PW'(ax[i][2] * bx[j][2]);
            ta1_ff[i] <= TW'(ax[i][0] * d[0]) + TW'(ax[i][1] * d[1]) + TW'(ax[i][2] * d[2]);
            tb1_ff[i] <= TW'(bx[i][0] * d[0]) + TW'(bx[i][1] * d[1]) + TW'(bx[i][2] * d[2]);
            ea1_ff[i] <= ea[i];
            eb1_ff[i] <= eb[i];
         end
      end
   end

   // Stage 2: floor to working scale (arithmetic shift floors) and take absolute axis dots.
   logic  v2_ff;
   c_type c2_ff [3][3];
   c_type ca2_ff [3][3];
   t_type ta2_ff [3];
   t_type tb2_ff [3];
   comp_type ea2_ff [3];
   comp_type eb2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               c2_ff[i][j] <= CW'(c1_ff[i][j] >>> AF);
               ca2_ff[i][j] <= c1_ff[i][j][PW-1] ? -CW'(c1_ff[i][j] >>> AF)
                                                 : CW'(c1_ff[i][j] >>> AF);
            end
            ta2_ff[i] <= FW'(ta1_ff[i] >>> AF);
            tb2_ff[i] <= FW'(tb1_ff[i] >>> AF);
            ea2_ff[i] <= ea1_ff[i];
            eb2_ff[i] <= eb1_ff[i];
         end
      end
   end

   // Stage 3: every product term for the fifteen tests.
   logic  v3_ff;
   s_type fa3_ff [3];   // |Ta| scaled
   s_type fb3_ff [3];
   s_type ra_a3_ff [3]; // ea[i] scaled
   s_type rb_b3_ff [3];
   s_type pb3_ff [3][3]; // eb[j]*ca[i][j]
   s_type pa3_ff [3][3]; // ea[i]*ca[i][j]
   s_type x13_ff [3][3]; // ta[i2]*c[i1][j]
   s_type x23_ff [3][3]; // ta[i1]*c[i2][j]
   s_type ra13_ff [3][3]; // ea[i1]*ca[i2][j]
   s_type ra23_ff [3][3]; // ea[i2]*ca[i1][j]
   s_type rb13_ff [3][3]; // eb[j1]*ca[i][j2]
   s_type rb23_ff [3][3]; // eb[j2]*ca[i][j1]
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            fa3_ff[i] <= (ta2_ff[i][FW-1] ? -SW'(ta2_ff[i]) : SW'(ta2_ff[i])) <<< AF;
            fb3_ff[i] <= (tb2_ff[i][FW-1] ? -SW'(tb2_ff[i]) : SW'(tb2_ff[i])) <<< AF;
            ra_a3_ff[i] <= SW'(ea2_ff[i]) <<< AF;
            rb_b3_ff[i] <= SW'(eb2_ff[i]) <<< AF;
            for (int j = 0; j < 3; j++) begin
               pb3_ff[i][j] <= SW'(eb2_ff[j] * ca2_ff[i][j]);
               pa3_ff[i][j] <= SW'(ea2_ff[i] * ca2_ff[i][j]);
               x13_ff[i][j] <= SW'(ta2_ff[(i+2)%3] * c2_ff[(i+1)%3][j]);
               x23_ff[i][j] <= SW'(ta2_ff[(i+1)%3] * c2_ff[(i+2)%3][j]);
               ra13_ff[i][j] <= SW'(ea2_ff[(i+1)%3] * ca2_ff[(i+2)%3][j]);
               ra23_ff[i][j] <= SW'(ea2_ff[(i+2)%3] * ca2_ff[(i+1)%3][j]);
               rb13_ff[i][j] <= SW'(eb2_ff[(j+1)%3] * ca2_ff[i][(j+2)%3]);
               rb23_ff[i][j] <= SW'(eb2_ff[(j+2)%3] * ca2_ff[i][(j+1)%3]);
            end
         end
      end
   end

   // Stage 4: projections and summed radii.
   logic  v4_ff;
   s_type lhs4_ff [NumAxes];
   s_type rhs4_ff [NumAxes];
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            lhs4_ff[i] <= fa3_ff[i];
            rhs4_ff[i] <= ra_a3_ff[i] + pb3_ff[i][0] + pb3_ff[i][1] + pb3_ff[i][2];
            lhs4_ff[3+i] <= fb3_ff[i];
            rhs4_ff[3+i] <= rb_b3_ff[i] + pa3_ff[0][i] + pa3_ff[1][i] + pa3_ff[2][i];
            for (int j = 0; j < 3; j++) begin
               lhs4_ff[6+3*i+j] <= x13_ff[i][j] - x23_ff[i][j];
               rhs4_ff[6+3*i+j] <= ra13_ff[i][j] + ra23_ff[i][j]
                  + rb13_ff[i][j] + rb23_ff[i][j];
            end
         end
      end
   end

   // Stage 5: compare each axis and pick the first separating one.
   logic [NumAxes-1:0] sep;
   logic [3:0]         first;
   always_comb begin
      first = AxisNone;
      for (int n = 0; n < NumAxes; n++) begin
         if (n >= 6)
            sep[n] = (lhs4_ff[n][SW-1] ? -lhs4_ff[n] : lhs4_ff[n]) > rhs4_ff[n];
         else
            sep[n] = lhs4_ff[n] > rhs4_ff[n];
      end
      for (int n = NumAxes - 1; n >= 0; n--)
         if (sep[n]) first = 4'(n);
   end

   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= v4_ff;
      if (advance) begin
         rsp_ff.overlap <= (first == AxisNone);
         rsp_ff.separating_axis <= first;
      end
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp.overlap = rsp_ff.overlap;
   assign rsp.separating_axis = rsp_ff.separating_axis;
endmodule

// ===== sv/obb_checker.sv =====
`timescale 1ns / 1ps
module obb_checker
   import obb_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_overlap,
   input logic [3:0] rsp_separating_axis
);
   // Overlap is reported exactly when no axis is named.
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_overlap == (rsp_separating_axis == AxisNone)))
      else $error("overlap flag disagrees with axis code");
   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_separating_axis))
      else $error("stalled response changed");
   // The input is blocked only while a response waits.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without backpressure");
   // No response comes out of an empty reset pipe.
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response right after reset");
endmodule

bind obb_overlap_separating_axis_top obb_checker u_obb_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_overlap(rsp.overlap),
   .rsp_separating_axis(rsp.separating_axis));
